FILE: src/lcd_seq_pkg.sv
package lcd_seq_pkg;

    // input selector codes
    typedef enum logic [2:0] {
        FUNC_TICK = 3'd0,
        FUNC_CMD  = 3'd1,
        FUNC_CHAR = 3'd2,
        FUNC_INIT = 3'd3,
        FUNC_MOVE = 3'd4
    } func_t;

    // what the back end does with a queued word
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_START = 2'd2
    } kind_t;

    // nibble sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HI_EN   = 3'd1,
        PH_HI_WAIT = 3'd2,
        PH_LO_EN   = 3'd3,
        PH_LO_WAIT = 3'd4
    } phase_t;

    // configuration register indexes
    localparam logic [1:0] REG_EN_PULSE   = 2'd0;
    localparam logic [1:0] REG_SHORT_WAIT = 2'd1;
    localparam logic [1:0] REG_LONG_WAIT  = 2'd2;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] INIT_LAST = 3'd5;

    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic [7:0] DDRAM_ROW1   = 8'h80;
    localparam logic [7:0] DDRAM_ROW2   = 8'hC0;

    // decoded word handed from front to back
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic       rs;
        logic       init;
    } lcd_cmd_t;

    // 4-bit power-up command sequence
    function automatic logic [7:0] init_rom(input logic [2:0] step);
        logic [7:0] b;
        case (step)
            3'd0:    b = 8'h33;
            3'd1:    b = 8'h32;
            3'd2:    b = 8'h28;
            3'd3:    b = 8'h0E;
            3'd4:    b = 8'h01;
            3'd5:    b = 8'h06;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: src/lcd_seq_front.sv
module lcd_seq_front (
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           func,
    input  logic [7:0]           value,
    input  logic [1:0]           row,
    input  logic [5:0]           column,
    output logic                 push,
    output lcd_seq_pkg::lcd_cmd_t cmd,
    input  logic                 q_ready
);
    import lcd_seq_pkg::*;

    logic [7:0] base;

    assign in_ready = q_ready;
    assign push     = in_valid && q_ready;
    assign base     = (row == 2'd1) ? DDRAM_ROW1 : DDRAM_ROW2;

    always_comb
    begin
        cmd.kind      = KIND_NONE;
        cmd.data_byte = value;
        cmd.rs        = 1'b0;
        cmd.init      = 1'b0;
        case (func)
            FUNC_TICK:
            begin
                cmd.kind = KIND_TICK;
            end
            FUNC_CMD:
            begin
                cmd.kind = KIND_START;
            end
            FUNC_CHAR:
            begin
                cmd.kind = KIND_START;
                cmd.rs   = 1'b1;
            end
            FUNC_INIT:
            begin
                cmd.kind      = KIND_START;
                cmd.init      = 1'b1;
                cmd.data_byte = init_rom(3'd0);
            end
            FUNC_MOVE:
            begin
                cmd.kind      = KIND_START;
                cmd.data_byte = base + {2'b00, column} - 8'd1;
            end
            default:
            begin
                cmd.kind = KIND_NONE;
            end
        endcase
    end

endmodule

FILE: src/lcd_seq_queue.sv
module lcd_seq_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lcd_seq_pkg::lcd_cmd_t push_cmd,
    output logic                  q_ready,
    input  logic                  pop,
    output logic                  q_valid,
    output lcd_seq_pkg::lcd_cmd_t head_cmd
);
    import lcd_seq_pkg::*;

    lcd_cmd_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign q_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign head_cmd = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue popped while empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with empty count");

endmodule

FILE: src/lcd_seq_back.sv
module lcd_seq_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  q_valid,
    input  lcd_seq_pkg::lcd_cmd_t head_cmd,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_rs,
    output logic                  out_en,
    output logic [3:0]            out_nibble,
    output logic                  out_busy,
    output logic                  out_accepted
);
    import lcd_seq_pkg::*;

    logic [7:0]  en_pulse_reg;
    logic [15:0] short_wait_reg;
    logic [15:0] long_wait_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] wait_reg, wait_next;
    logic [7:0]  byte_reg, byte_next;
    logic        rs_reg, rs_next;
    logic [2:0]  step_reg, step_next;
    logic        init_reg, init_next;

    logic        out_valid_reg, out_valid_next;
    logic        rs_out_reg;
    logic        en_out_reg;
    logic [3:0]  nibble_out_reg;
    logic        busy_out_reg;
    logic        acc_out_reg;

    logic [15:0] en_len;
    logic [15:0] wait_len;
    logic [15:0] wait_dec;
    logic        acc;

    assign en_len   = {8'd0, (en_pulse_reg == 8'd0) ? 8'd1 : en_pulse_reg};
    assign wait_len = (!rs_reg && (byte_reg == CMD_CLEAR || byte_reg == CMD_HOME))
                    ? ((long_wait_reg == 16'd0) ? 16'd1 : long_wait_reg)
                    : ((short_wait_reg == 16'd0) ? 16'd1 : short_wait_reg);
    assign wait_dec = (wait_reg != 16'd0) ? wait_reg - 16'd1 : 16'd0;

    assign pop            = q_valid && (!out_valid_reg || out_ready);
    assign out_valid_next = pop || (out_valid_reg && !out_ready);

    // next state of the sequencer for the word at the queue head
    always_comb
    begin
        phase_next = phase_reg;
        wait_next  = wait_reg;
        byte_next  = byte_reg;
        rs_next    = rs_reg;
        step_next  = step_reg;
        init_next  = init_reg;
        acc        = 1'b0;
        if (pop)
        begin
            case (head_cmd.kind)
                KIND_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        if (wait_dec != 16'd0)
                        begin
                            wait_next = wait_dec;
                        end
                        else
                        begin
                            case (phase_reg)
                                PH_HI_EN:
                                begin
                                    phase_next = PH_HI_WAIT;
                                    wait_next  = wait_len;
                                end
                                PH_HI_WAIT:
                                begin
                                    phase_next = PH_LO_EN;
                                    wait_next  = en_len;
                                end
                                PH_LO_EN:
                                begin
                                    phase_next = PH_LO_WAIT;
                                    wait_next  = wait_len;
                                end
                                default:
                                begin
                                    if (init_reg && step_reg < INIT_LAST)
                                    begin
                                        step_next  = step_reg + 3'd1;
                                        byte_next  = init_rom(step_reg + 3'd1);
                                        rs_next    = 1'b0;
                                        phase_next = PH_HI_EN;
                                        wait_next  = en_len;
                                    end
                                    else
                                    begin
                                        init_next  = 1'b0;
                                        phase_next = PH_IDLE;
                                        wait_next  = 16'd0;
                                    end
                                end
                            endcase
                        end
                    end
                end
                KIND_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        byte_next  = head_cmd.data_byte;
                        rs_next    = head_cmd.rs;
                        phase_next = PH_HI_EN;
                        wait_next  = en_len;
                        acc        = 1'b1;
                        if (head_cmd.init)
                        begin
                            init_next = 1'b1;
                            step_next = 3'd0;
                        end
                    end
                end
                default:
                begin
                    acc = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_pulse_reg   <= 8'd1;
            short_wait_reg <= 16'd100;
            long_wait_reg  <= 16'd2000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EN_PULSE:   en_pulse_reg   <= cfg_data[7:0];
                REG_SHORT_WAIT: short_wait_reg <= cfg_data;
                REG_LONG_WAIT:  long_wait_reg  <= cfg_data;
                default:        en_pulse_reg   <= en_pulse_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            wait_reg      <= 16'd0;
            byte_reg      <= 8'd0;
            rs_reg        <= 1'b0;
            step_reg      <= 3'd0;
            init_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            wait_reg      <= wait_next;
            byte_reg      <= byte_next;
            rs_reg        <= rs_next;
            step_reg      <= step_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // pin levels after this word
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rs_out_reg     <= rs_next;
            en_out_reg     <= (phase_next == PH_HI_EN || phase_next == PH_LO_EN);
            nibble_out_reg <= (phase_next == PH_HI_EN || phase_next == PH_HI_WAIT)
                            ? byte_next[7:4] : byte_next[3:0];
            busy_out_reg   <= (phase_next != PH_IDLE);
            acc_out_reg    <= acc;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_rs       = rs_out_reg;
    assign out_en       = en_out_reg;
    assign out_nibble   = nibble_out_reg;
    assign out_busy     = busy_out_reg;
    assign out_accepted = acc_out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (wait_reg == 16'd0 && !init_reg))
        else $error("idle sequencer holds a count or init flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (wait_reg != 16'd0))
        else $error("active phase with an empty counter");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && acc) |=> (out_valid_reg && acc_out_reg && en_out_reg && busy_out_reg))
        else $error("accepted word did not start the high nibble");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(acc_out_reg) && $stable(nibble_out_reg))
        else $error("stalled result changed");

endmodule

FILE: src/char_lcd_nibble_write_sequencer.sv
// Character LCD write sequencer for a 4-bit HD44780-style bus. Each input word
// carries a selector in s_axis_tuser: tick, command byte, character byte, run
// init or cursor move. A write, init or move taken while the display is idle
// starts the high nibble at once (en high in that result) and is flagged as
// accepted; one sent while busy is dropped with accepted low. Every nibble is
// an enable pulse of REG_EN_PULSE ticks followed by a wait, long after clear
// or home commands and short otherwise; a register value of zero counts as one.
// Init plays the six-command 4-bit power-up sequence. Every input word yields
// exactly one result word with the pin levels after that word. It takes one
// word per clock while m_axis_tready holds no result back; each word passes
// the decode queue, then the result register. The front decodes into a
// two-entry queue so input flows while a result waits, until the queue fills.
module char_lcd_nibble_write_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // value[7:0], row[9:8], column[15:10]
    input  logic [2:0]  s_axis_tuser,   // func[2:0]
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // rw[0], en[1], data_nibble[5:2], busy_res[6], accepted[7]
    output logic [0:0]  m_axis_tuser    // rs[0]
);
    import lcd_seq_pkg::*;

    lcd_cmd_t   push_cmd;
    lcd_cmd_t   head_cmd;
    logic       push;
    logic       q_ready;
    logic       q_valid;
    logic       pop;
    logic       out_rs;
    logic       out_en;
    logic [3:0] out_nibble;
    logic       out_busy;
    logic       out_accepted;

    // decode the selector and build the byte to send
    lcd_seq_front u_front (
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .func     (s_axis_tuser),
        .value    (s_axis_tdata[7:0]),
        .row      (s_axis_tdata[9:8]),
        .column   (s_axis_tdata[15:10]),
        .push     (push),
        .cmd      (push_cmd),
        .q_ready  (q_ready)
    );

    // short queue between decode and the nibble sequencer
    lcd_seq_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .q_ready  (q_ready),
        .pop      (pop),
        .q_valid  (q_valid),
        .head_cmd (head_cmd)
    );

    // timing registers, phase counter and result register
    lcd_seq_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_valid      (q_valid),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_rs       (out_rs),
        .out_en       (out_en),
        .out_nibble   (out_nibble),
        .out_busy     (out_busy),
        .out_accepted (out_accepted)
    );

    // rw is tied low: the block only writes
    assign m_axis_tdata = {out_accepted, out_busy, out_nibble, out_en, 1'b0};
    assign m_axis_tuser = out_rs;

endmodule
